// File: rtl/ddw_pkg.sv
// Package for the decimal display writer.
// Word types, job type and bus constants shared by all ddw modules.
// No dependencies.
package ddw_pkg;

  localparam int MaxDigitsDef  = 10;
  localparam int ValueWidthDef = 32;
  localparam int QueueDepth    = 2;
  localparam int CountW        = 4;
  localparam int DigitW        = 4;

  localparam logic [1:0] LineOne     = 2'd1;
  localparam logic [1:0] LineTwo     = 2'd2;
  localparam logic [7:0] CmdSetAddr  = 8'h80;
  localparam logic [7:0] Line2Offset = 8'h40;
  localparam logic [7:0] AsciiZero   = 8'h30;

  typedef struct packed {
    logic [1:0]        line_number;
    logic [5:0]        column_number;
    logic [31:0]       number_value;
    logic [CountW-1:0] digit_count;
  } in_word_t;

  typedef struct packed {
    logic       is_character;
    logic [7:0] bus_value;
    logic       final_write;
  } out_word_t;

  // classified request handed from front to back
  typedef struct packed {
    logic              has_cmd;
    logic [7:0]        cmd_byte;
    logic [31:0]       number_value;
    logic [CountW-1:0] digit_count;
  } job_t;

endpackage

// File: rtl/ddw_front.sv
// Front end: accepts request words, builds the set-address byte, saturates
// the digit count and masks the value. Uses ddw_pkg.
module ddw_front import ddw_pkg::*; #(
  parameter int MAX_DIGITS  = MaxDigitsDef,
  parameter int VALUE_WIDTH = ValueWidthDef
) (
  input  logic     start,
  output logic     busy,
  input  in_word_t in_word,
  input  logic     q_full,
  output logic     q_push,
  output job_t     q_job
);

  logic              has_cmd;
  logic [7:0]        addr;
  logic [CountW-1:0] count_sat;
  logic [31:0]       value_mask;

  always_comb begin
    has_cmd = (in_word.line_number == LineOne) || (in_word.line_number == LineTwo);
    addr = {2'b00, in_word.column_number} - 8'd1;
    if (in_word.line_number == LineTwo) begin
      addr = addr + Line2Offset;
    end
    if (in_word.digit_count > CountW'(MAX_DIGITS)) begin
      count_sat = CountW'(MAX_DIGITS);
    end else begin
      count_sat = in_word.digit_count;
    end
    value_mask = 32'(in_word.number_value[VALUE_WIDTH-1:0]);
  end

  assign busy = q_full;

  // a request with no command and no digits yields nothing: dropped here
  assign q_push = start && !q_full && (has_cmd || (count_sat != '0));

  assign q_job = '{has_cmd:      has_cmd,
                   cmd_byte:     CmdSetAddr | addr,
                   number_value: value_mask,
                   digit_count:  count_sat};

endmodule

// File: rtl/ddw_queue.sv
// Short job queue between front and back ends (flip-flop storage).
// Uses ddw_pkg for job_t and QueueDepth.
module ddw_queue import ddw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head_job,
  output logic not_empty,
  output logic full
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  job_t            entry_r [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] fill_r;

  assign not_empty = (fill_r != '0);
  assign full      = (fill_r == CntW'(QueueDepth));
  assign head_job  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: rtl/ddw_back.sv
// Back end: one shared divide-by-ten step per cycle pushes digits onto a
// small stack, then pops them out MSB first as data writes. Uses ddw_pkg.
module ddw_back import ddw_pkg::*; #(
  parameter int MAX_DIGITS  = MaxDigitsDef,
  parameter int VALUE_WIDTH = ValueWidthDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  input  job_t      job,
  output logic      job_pop,
  output logic      out_strobe,
  output out_word_t out_word
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  // ceil(2^(W+3)/10): exact quotient for every W-bit value after >> (W+3)
  localparam logic [VALUE_WIDTH-1:0] Recip =
    VALUE_WIDTH'(((64'd1 << (VALUE_WIDTH + 3)) + 64'd9) / 64'd10);

  logic [1:0]              state_r, state_nxt;
  logic [VALUE_WIDTH-1:0]  value_r;
  logic [CountW-1:0]       div_left_r;
  logic [CountW-1:0]       emit_left_r;
  logic                    cmd_pend_r;
  logic [7:0]              cmd_byte_r;
  logic [DigitW-1:0]       stack_r [MAX_DIGITS];
  logic                    out_strobe_r;
  out_word_t               out_word_r;

  logic [2*VALUE_WIDTH-1:0] prod;
  logic [VALUE_WIDTH-1:0]   quot;
  logic [DigitW-1:0]        rem;
  logic                     push_dig;
  logic                     pop_dig;

  always_comb begin
    prod = {{VALUE_WIDTH{1'b0}}, value_r} * {{VALUE_WIDTH{1'b0}}, Recip};
    quot = VALUE_WIDTH'(prod >> (VALUE_WIDTH + 3));
    rem  = DigitW'(value_r - ((quot << 3) + (quot << 1)));
  end

  assign job_pop  = (state_r == S_IDLE) && job_valid;
  assign push_dig = (state_r == S_DIV) && (div_left_r != '0);
  assign pop_dig  = (state_r == S_EMIT);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_left_r <= CountW'(1)) begin
          state_nxt = (emit_left_r == '0) ? S_IDLE : S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_left_r == CountW'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
      cmd_pend_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= 1'b0;
      if (job_pop) begin
        cmd_pend_r <= job.has_cmd;
      end
      if (state_r == S_DIV && cmd_pend_r) begin
        out_strobe_r <= 1'b1;
        cmd_pend_r   <= 1'b0;
      end
      if (pop_dig) begin
        out_strobe_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      value_r     <= job.number_value[VALUE_WIDTH-1:0];
      div_left_r  <= job.digit_count;
      emit_left_r <= job.digit_count;
      cmd_byte_r  <= job.cmd_byte;
    end
    if (push_dig) begin
      value_r    <= quot;
      div_left_r <= div_left_r - 1'b1;
    end
    // command goes out in the first divide cycle; final if no digits follow
    if (state_r == S_DIV && cmd_pend_r) begin
      out_word_r <= '{is_character: 1'b0,
                      bus_value:    cmd_byte_r,
                      final_write:  (emit_left_r == '0)};
    end
    if (pop_dig) begin
      out_word_r <= '{is_character: 1'b1,
                      bus_value:    AsciiZero + {4'b0000, stack_r[0]},
                      final_write:  (emit_left_r == CountW'(1))};
      emit_left_r <= emit_left_r - 1'b1;
    end
  end

  // digit stack: newest at index 0, so the high digit pops first
  always_ff @(posedge clk) begin
    if (push_dig) begin
      for (int i = MAX_DIGITS - 1; i > 0; i--) begin
        stack_r[i] <= stack_r[i-1];
      end
      stack_r[0] <= rem;
    end else if (pop_dig) begin
      for (int i = 0; i < MAX_DIGITS - 1; i++) begin
        stack_r[i] <= stack_r[i+1];
      end
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

// File: rtl/decimal_display_writer.sv
// Top level of the decimal display writer: front end, job queue, back end.
// Depends on ddw_pkg, ddw_front, ddw_queue, ddw_back.
//
//  channel  | ports                     | handshake
//  ---------+---------------------------+----------------------------------
//  request  | start, busy, in_word      | word taken when start && !busy
//  bus write| out_strobe, out_word      | one cycle per word, no back-pressure
//
// In the back end a request is taken in the idle state, the single divide-by-ten unit
// splits off its digits in the divide state and the digit stack emits one write per
// cycle in the emit state. The set-address write overlaps the first divide.
// busy rises only when the two-entry job queue is full. Requests with no
// command and no digits produce no writes. Reset is synchronous, active low.
module decimal_display_writer import ddw_pkg::*; #(
  parameter int MAX_DIGITS  = MaxDigitsDef,
  parameter int VALUE_WIDTH = ValueWidthDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_strobe,
  output out_word_t out_word
);

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_not_empty;
  job_t q_in_job;
  job_t q_head_job;

  ddw_front #(
    .MAX_DIGITS  (MAX_DIGITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .start   (start),
    .busy    (busy),
    .in_word (in_word),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (q_in_job)
  );

  ddw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_in_job),
    .pop       (q_pop),
    .head_job  (q_head_job),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  ddw_back #(
    .MAX_DIGITS  (MAX_DIGITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (q_not_empty),
    .job        (q_head_job),
    .job_pop    (q_pop),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for decimal_display_writer.
// Drives requests in random bursts and checks each bus write against an
// in-line predictor. Depends on ddw_pkg and the decimal_display_writer RTL.
`timescale 1ns / 1ps

module testbench;
  import ddw_pkg::*;

  localparam int MaxDigitShown = MaxDigitsDef;
  localparam int RandomRequests = 420;
  localparam int TailCycles = 100;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_strobe;
  out_word_t out_word;

  in_word_t  pending_requests[$];
  out_word_t expected_writes[$];
  int        mismatch_count = 0;

  // driver bookkeeping, touched only by the driver block, and the monitor's expected word
  int        burst_left = 0;
  int        gap_left = 0;
  logic      drive_next;
  out_word_t want;

  decimal_display_writer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Expected bus writes for one accepted request, in emission order.
  task automatic queue_lcd_writes(input in_word_t req);
    out_word_t   w;
    logic [3:0]  digits[MaxDigitShown];
    logic [31:0] rest;
    logic [7:0]  addr;
    int          n_digits;
    int          total;
    int          k;
    n_digits = (req.digit_count > MaxDigitShown) ? MaxDigitShown : int'(req.digit_count);
    total = n_digits;
    k = 0;
    if (req.line_number == LineOne || req.line_number == LineTwo) begin
      total++;
      // column 0 wraps to 0xFF before the line offset is added
      addr = {2'b00, req.column_number} - 8'd1;
      if (req.line_number == LineTwo) begin
        addr = addr + Line2Offset;
      end
      w.is_character = 1'b0;
      w.bus_value = CmdSetAddr | addr;
      w.final_write = (k == total - 1);
      expected_writes.push_back(w);
      k++;
    end
    rest = req.number_value;
    for (int i = 0; i < n_digits; i++) begin
      digits[i] = 4'(rest % 10);
      rest = rest / 10;
    end
    for (int i = n_digits - 1; i >= 0; i--) begin
      w.is_character = 1'b1;
      w.bus_value = AsciiZero + {4'b0000, digits[i]};
      w.final_write = (k == total - 1);
      expected_writes.push_back(w);
      k++;
    end
  endtask

  task automatic add_request(input logic [1:0] line, input logic [5:0] col,
                             input logic [31:0] value, input logic [3:0] count);
    in_word_t req;
    req.line_number = line;
    req.column_number = col;
    req.number_value = value;
    req.digit_count = count;
    pending_requests.push_back(req);
  endtask

  function automatic logic [31:0] random_number();
    logic [31:0] p;
    int k;
    p = 32'd1;
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 99);
      2: begin
        // around a power of ten, where digit counts change
        k = $urandom_range(1, 9);
        for (int i = 0; i < k; i++) p = p * 10;
        return p - $urandom_range(0, 1);
      end
      3: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom_range(0, 99999);
    endcase
  endfunction

  // Driver: start held high through a burst, dropped for a random gap after it.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_word <= '0;
    end else begin
      drive_next = start;
      if (start && !busy) begin
        queue_lcd_writes(in_word);
        void'(pending_requests.pop_front());
        drive_next = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          case ($urandom_range(0, 3))
            0, 3: gap_left = 0;
            1: gap_left = $urandom_range(1, 3);
            default: gap_left = $urandom_range(4, 25);
          endcase
        end
      end
      if (!drive_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_requests.size() > 0) begin
          if (burst_left == 0) burst_left = $urandom_range(1, 16);
          drive_next = 1'b1;
        end
      end
      start <= drive_next;
      if (drive_next) in_word <= pending_requests[0];
    end
  end

  // Monitor: every strobed word must match the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected word rs=%0b bus=%02h last=%0b",
                                  out_word.is_character, out_word.bus_value,
                                  out_word.final_write));
      end else begin
        want = expected_writes.pop_front();
        if (out_word.is_character !== want.is_character ||
            out_word.bus_value !== want.bus_value ||
            out_word.final_write !== want.final_write) begin
          report_mismatch($sformatf("got rs=%0b bus=%02h last=%0b, want rs=%0b bus=%02h last=%0b",
                                    out_word.is_character, out_word.bus_value,
                                    out_word.final_write, want.is_character,
                                    want.bus_value, want.final_write));
        end
      end
    end
  end

  initial begin
    int counted;
    logic [1:0] line;
    logic [5:0] col;
    logic [3:0] count;

    // directed: field extremes, wraps, skipped command, empty runs, saturation
    add_request(2'd1, 6'd1,  32'd0,          4'd1);
    add_request(2'd2, 6'd40, 32'hFFFF_FFFF,  4'd10);
    add_request(2'd0, 6'd5,  32'd12345,      4'd5);
    add_request(2'd3, 6'd63, 32'd987654321,  4'd9);
    add_request(2'd1, 6'd0,  32'd7,          4'd3);
    add_request(2'd2, 6'd0,  32'd42,         4'd2);
    add_request(2'd1, 6'd63, 32'd5,          4'd0);
    add_request(2'd2, 6'd17, 32'd5,          4'd0);
    add_request(2'd0, 6'd3,  32'd99,         4'd0);
    add_request(2'd3, 6'd9,  32'hFFFF_FFFF,  4'd0);
    add_request(2'd2, 6'd20, 32'hFFFF_FFFF,  4'd15);
    add_request(2'd1, 6'd2,  32'd1234567890, 4'd11);
    add_request(2'd0, 6'd1,  32'd0,          4'd10);
    add_request(2'd2, 6'd1,  32'd1000000000, 4'd10);
    add_request(2'd1, 6'd32, 32'd999999999,  4'd4);
    add_request(2'd2, 6'd63, 32'd9,          4'd1);
    add_request(2'd0, 6'd0,  32'hFFFF_FFFF,  4'd15);
    add_request(2'd1, 6'd42, 32'h8000_0000,  4'd12);
    add_request(2'd3, 6'd21, 32'h5555_5555,  4'd10);
    add_request(2'd2, 6'd42, 32'hAAAA_AAAA,  4'd10);

    counted = 0;
    while (counted < RandomRequests) begin
      line = 2'($urandom_range(0, 3));
      col = ($urandom_range(0, 6) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(1, 40));
      count = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 10));
      add_request(line, col, random_number(), count);
      // requests with neither command nor digits are ignored by the block
      if (count != 0 || line == LineOne || line == LineTwo) counted++;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || start || expected_writes.size() != 0) begin
      @(posedge clk);
    end
    repeat (TailCycles) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
